/* rtl/spq_pkg.sv */
// Shared types and constants for the sorted-array priority queue.
// No dependencies; imported by the datapath, controller and top level.
`default_nettype none

package spq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned KEY_WIDTH_DEF   = 32;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned CAP_W           = 7;
  localparam logic [CAP_W-1:0] CAP_RESET  = 7'd64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_REM_RD,
    ST_REM_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic take;
    logic pos_load_cnt;
    logic pos_clr;
    logic pos_dec;
    logic pos_inc;
    logic rd_pos;
    logic rd_pos_m1;
    logic wr_key_pos;
    logic wr_rd_pos;
    logic wr_rd_pos_m1;
    logic cap_front;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic set_ok;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic cnt_zero;
    logic full;
    logic pos_zero;
    logic pos_last;
    logic rd_gt_key;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/spq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/spq_datapath.sv */
// Datapath: entry RAM, count, capacity, position pointer and output word register.
// Depends on spq_pkg and spq_ram; driven by spq_ctrl commands.
`default_nettype none

module spq_datapath #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH   = spq_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [1:0]                       opcode_i,
  input  wire logic [spq_pkg::VAL_W-1:0]        value_in_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [spq_pkg::CAP_W-1:0]        cfg_wdata_i,
  input  wire spq_pkg::dp_cmd_t                 cmd_i,
  output spq_pkg::dp_status_t                   status_o,
  input  wire logic                             out_stall_i,
  output logic                                  out_valid_o,
  output logic                                  ok_o,
  output logic [spq_pkg::VAL_W-1:0]             front_value_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      entry_count_o,
  output logic                                  is_empty_o,
  output logic                                  is_full_o
);
  import spq_pkg::*;

  localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  op_e                  op_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     pos_q, pos_d, pos_m1;
  logic [CAP_W-1:0]     cap_q;
  logic [KEY_WIDTH-1:0] front_q;
  logic                 ok_q;
  logic                 out_valid_q;
  logic                 out_ok_q;
  logic [VAL_W-1:0]     out_front_q;
  logic [CNT_W-1:0]     out_count_q;
  logic                 out_empty_q, out_full_q;

  logic [KEY_WIDTH+VAL_W-1:0] key_ext;
  logic [KEY_WIDTH+VAL_W-1:0] front_ext;
  logic [KEY_WIDTH-1:0]       rd_data;
  logic                       we;
  logic [AW-1:0]              waddr, raddr;
  logic [KEY_WIDTH-1:0]       wdata;
  logic                       full;

  assign key_ext   = {{KEY_WIDTH{1'b0}}, value_in_i};
  assign front_ext = {{VAL_W{1'b0}}, front_q};
  assign pos_m1    = pos_q - CNT_W'(1);

  // full when count reaches capacity, or the whole array when capacity exceeds it
  assign full = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (count_q == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    we    = 1'b0;
    waddr = pos_q[AW-1:0];
    wdata = key_q;
    if (cmd_i.wr_key_pos) begin
      we = 1'b1;
    end else if (cmd_i.wr_rd_pos) begin
      we    = 1'b1;
      wdata = rd_data;
    end else if (cmd_i.wr_rd_pos_m1) begin
      we    = 1'b1;
      waddr = pos_m1[AW-1:0];
      wdata = rd_data;
    end
    raddr = cmd_i.rd_pos_m1 ? pos_m1[AW-1:0] : pos_q[AW-1:0];
  end

  spq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.cnt_inc) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.pos_load_cnt) begin
      pos_d = count_q;
    end else if (cmd_i.pos_clr) begin
      pos_d = '0;
    end else if (cmd_i.pos_dec) begin
      pos_d = pos_m1;
    end else if (cmd_i.pos_inc) begin
      pos_d = pos_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.take) begin
      op_q    <= op_e'(opcode_i);
      key_q   <= key_ext[KEY_WIDTH-1:0];
      ok_q    <= 1'b0;
      front_q <= '0;
    end else begin
      if (cmd_i.set_ok) begin
        ok_q <= 1'b1;
      end
      if (cmd_i.cap_front) begin
        front_q <= rd_data;
      end
    end
    if (cmd_i.out_load) begin
      out_ok_q    <= ok_q;
      out_front_q <= front_ext[VAL_W-1:0];
      out_count_q <= count_q;
      out_empty_q <= (count_q == '0);
      out_full_q  <= full;
    end
  end

  assign status_o.op        = op_q;
  assign status_o.cnt_zero  = (count_q == '0);
  assign status_o.full      = full;
  assign status_o.pos_zero  = (pos_q == '0);
  assign status_o.pos_last  = ((pos_q + CNT_W'(1)) == count_q);
  assign status_o.rd_gt_key = (rd_data > key_q);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign front_value_o = out_front_q;
  assign entry_count_o = out_count_q;
  assign is_empty_o    = out_empty_q;
  assign is_full_o     = out_full_q;

endmodule

`default_nettype wire

/* rtl/spq_ctrl.sv */
// Controller state machine: sequences insert shifts, remove shifts, peeks and clears.
// Depends on spq_pkg; drives spq_datapath through the command struct.
`default_nettype none

module spq_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire spq_pkg::dp_status_t status_i,
  output spq_pkg::dp_cmd_t         cmd_o
);
  import spq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status_i.op)
          OP_INSERT: state_d = status_i.full ? ST_RESP : ST_INS_RD;
          OP_REMOVE,
          OP_PEEK:   state_d = status_i.cnt_zero ? ST_RESP : ST_REM_RD;
          default:   state_d = ST_RESP;
        endcase
      end
      ST_INS_RD: begin
        state_d = status_i.pos_zero ? ST_RESP : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        state_d = status_i.rd_gt_key ? ST_INS_RD : ST_RESP;
      end
      ST_REM_RD: begin
        state_d = ST_REM_WR;
      end
      ST_REM_WR: begin
        if (status_i.op == OP_PEEK || status_i.pos_last) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_REM_RD;
        end
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
      end
      ST_DECODE: begin
        case (status_i.op)
          OP_INSERT: cmd_o.pos_load_cnt = !status_i.full;
          OP_REMOVE,
          OP_PEEK:   cmd_o.pos_clr = !status_i.cnt_zero;
          default: begin
            cmd_o.cnt_clr = 1'b1;
            cmd_o.set_ok  = 1'b1;
          end
        endcase
      end
      ST_INS_RD: begin
        if (status_i.pos_zero) begin
          cmd_o.wr_key_pos = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.set_ok     = 1'b1;
        end else begin
          cmd_o.rd_pos_m1 = 1'b1;
        end
      end
      ST_INS_CMP: begin
        if (status_i.rd_gt_key) begin
          cmd_o.wr_rd_pos = 1'b1;
          cmd_o.pos_dec   = 1'b1;
        end else begin
          cmd_o.wr_key_pos = 1'b1;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.set_ok     = 1'b1;
        end
      end
      ST_REM_RD: begin
        cmd_o.rd_pos = 1'b1;
      end
      ST_REM_WR: begin
        if (status_i.pos_zero) begin
          cmd_o.cap_front = 1'b1;
        end else begin
          cmd_o.wr_rd_pos_m1 = 1'b1;
        end
        if (status_i.op == OP_PEEK) begin
          cmd_o.set_ok = 1'b1;
        end else if (status_i.pos_last) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.set_ok  = 1'b1;
        end else begin
          cmd_o.pos_inc = 1'b1;
        end
      end
      ST_RESP: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sorted_array_priority_queue_unit.sv */
// Sorted-array min-priority queue. Insert walks from the back, shifting each stored key
// greater than the new key up one place before writing it; remove reads the front and
// shifts every other entry down one place; peek reads only the front; clear or a
// rejected word goes straight to the output word. One word at a time: the next word is
// taken in the cycle after the output word loads, and a stalled output word holds it off.
// Reset empties the queue and sets capacity to 64; RAM contents are left as is.
`default_nettype none

module sorted_array_priority_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned KEY_WIDTH   = spq_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [spq_pkg::CAP_W-1:0]        cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       opcode_i,
  input  wire logic [spq_pkg::VAL_W-1:0]        value_in_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  ok_o,
  output logic [spq_pkg::VAL_W-1:0]             front_value_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      entry_count_o,
  output logic                                  is_empty_o,
  output logic                                  is_full_o
);
  import spq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode_i),
    .value_in_i    (value_in_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .ok_o          (ok_o),
    .front_value_o (front_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o)
  );

endmodule

`default_nettype wire

/* rtl/spq_checker.sv */
// Port-level checks for the sorted-array priority queue, bound to the top level.
// Depends on spq_pkg and sorted_array_priority_queue_unit.
`default_nettype none

module spq_checker #(
  parameter int unsigned CNT_W = 7
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic                      ok_o,
  input wire logic [spq_pkg::VAL_W-1:0] front_value_o,
  input wire logic [CNT_W-1:0]          entry_count_o,
  input wire logic                      is_empty_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted word");

  a_empty_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("is_empty disagrees with entry_count");

  a_reject_front_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (front_value_o == '0))
    else $error("rejected word carries nonzero front value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(front_value_o)))
    else $error("stalled output word changed");

endmodule

bind sorted_array_priority_queue_unit spq_checker #(
  .CNT_W ($clog2(QUEUE_DEPTH + 1))
) u_spq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .ok_o          (ok_o),
  .front_value_o (front_value_o),
  .entry_count_o (entry_count_o),
  .is_empty_o    (is_empty_o)
);

`default_nettype wire
